[rtl/dmrw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmrw_pkg;

    // Field and register widths
    localparam int SPEED_W      = 9;
    localparam int TARGET_W     = 16;
    localparam int CMD_W        = 2;
    localparam int TIMEOUT_W    = 16;
    localparam int PERIOD_W     = 8;
    localparam int STEP_W       = 9;
    localparam int SINCE_CMD_W  = 17;
    localparam int SINCE_RAMP_W = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    // Stream packing
    localparam int S_TDATA_W = 2 * TARGET_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // Speed limit applied to set-speed targets
    localparam int SPEED_MAX = 255;
    localparam logic signed [TARGET_W-1:0] SPEED_MAX_TGT = TARGET_W'(SPEED_MAX);
    localparam logic signed [TARGET_W-1:0] SPEED_MIN_TGT = TARGET_W'(-SPEED_MAX);
    localparam logic signed [SPEED_W-1:0]  SPEED_MAX_DRV = SPEED_W'(SPEED_MAX);
    localparam logic signed [SPEED_W-1:0]  SPEED_MIN_DRV = SPEED_W'(-SPEED_MAX);

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(5);
    localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(10);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT = 2'd0,
        REG_PERIOD  = 2'd1,
        REG_STEP    = 2'd2
    } reg_index_t;

    // One ramp lane's outcome
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      updated;
    } lane_result_t;

    // Limit a requested speed to the allowed range
    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [TARGET_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > SPEED_MAX_TGT)
        begin
            r = SPEED_MAX_DRV;
        end
        else if (v < SPEED_MIN_TGT)
        begin
            r = SPEED_MIN_DRV;
        end
        else
        begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/dual_motor_ramp_with_watchdog.sv]
// A request accepted from the input stream passes the input register, then the
// result register, before its result is offered.
// Throughput: one request per cycle unless the result stream stalls; the state
// update is a single pass of add, compare and clamp between the input and result registers.
// Reset (rst_n low, asynchronous): speeds, goals and counters clear to zero,
// registers return to timeout 1000, period 5, step 10, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_ramp_with_watchdog (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [dmrw_pkg::S_TDATA_W-1:0]      s_tdata,  // left_target, right_target
    input  wire logic [dmrw_pkg::CMD_W-1:0]          s_tuser,  // command
    // Result stream
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [dmrw_pkg::M_TDATA_W-1:0]      m_tdata,  // left_drive, right_drive, zeros
    output      logic [dmrw_pkg::M_TUSER_W-1:0]      m_tuser,  // left_updated, right_updated, stopped
    // Configuration writes
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [dmrw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dmrw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = dmrw_pkg::SPEED_W;
    localparam int TW = dmrw_pkg::TARGET_W;

    // Configuration registers
    logic [dmrw_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [dmrw_pkg::PERIOD_W-1:0]  period_reg;
    logic [dmrw_pkg::STEP_W-1:0]    step_reg;

    // Input register
    logic                           in_valid_reg;
    dmrw_pkg::cmd_t                 in_cmd_reg;
    logic signed [TW-1:0]           in_left_reg;
    logic signed [TW-1:0]           in_right_reg;

    // Control state
    logic signed [SW-1:0]                 cur_left_reg,  cur_left_next;
    logic signed [SW-1:0]                 cur_right_reg, cur_right_next;
    logic signed [SW-1:0]                 goal_left_reg, goal_left_next;
    logic signed [SW-1:0]                 goal_right_reg, goal_right_next;
    logic [dmrw_pkg::SINCE_CMD_W-1:0]     since_cmd_reg, since_cmd_next;
    logic [dmrw_pkg::SINCE_RAMP_W-1:0]    since_ramp_reg, since_ramp_next;

    // Result register
    logic                           out_valid_reg;
    logic signed [SW-1:0]           out_left_reg;
    logic signed [SW-1:0]           out_right_reg;
    logic                           out_lu_reg, out_lu_next;
    logic                           out_ru_reg, out_ru_next;
    logic                           out_stop_reg, out_stop_next;

    logic                           fire;
    logic [dmrw_pkg::SINCE_CMD_W-1:0]  since_cmd_inc;
    logic [dmrw_pkg::SINCE_RAMP_W-1:0] since_ramp_inc;
    dmrw_pkg::lane_result_t         left_lane;
    dmrw_pkg::lane_result_t         right_lane;

    // Handshakes: process when the result register is free or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= dmrw_pkg::TIMEOUT_RESET;
            period_reg  <= dmrw_pkg::PERIOD_RESET;
            step_reg    <= dmrw_pkg::STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dmrw_pkg::reg_index_t'(cfg_index))
                dmrw_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[dmrw_pkg::TIMEOUT_W-1:0];
                dmrw_pkg::REG_PERIOD:  period_reg  <= cfg_data[dmrw_pkg::PERIOD_W-1:0];
                dmrw_pkg::REG_STEP:    step_reg    <= cfg_data[dmrw_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= dmrw_pkg::cmd_t'(s_tuser);
            in_left_reg  <= $signed(s_tdata[TW-1:0]);
            in_right_reg <= $signed(s_tdata[2*TW-1:TW]);
        end
    end

    // Ramp lanes
    dmrw_ramp_lane u_lane_left (
        .cur    (cur_left_reg),
        .goal   (goal_left_reg),
        .step   (step_reg),
        .result (left_lane)
    );

    dmrw_ramp_lane u_lane_right (
        .cur    (cur_right_reg),
        .goal   (goal_right_reg),
        .step   (step_reg),
        .result (right_lane)
    );

    // Saturating counters
    assign since_cmd_inc  = (&since_cmd_reg) ? since_cmd_reg : since_cmd_reg + 1'b1;
    assign since_ramp_inc = (&since_ramp_reg) ? since_ramp_reg : since_ramp_reg + 1'b1;

    // Per-request state update
    always_comb
    begin
        cur_left_next   = cur_left_reg;
        cur_right_next  = cur_right_reg;
        goal_left_next  = goal_left_reg;
        goal_right_next = goal_right_reg;
        since_cmd_next  = since_cmd_reg;
        since_ramp_next = since_ramp_reg;
        out_lu_next     = 1'b0;
        out_ru_next     = 1'b0;
        out_stop_next   = 1'b0;
        case (in_cmd_reg)
            dmrw_pkg::CMD_TICK:
            begin
                since_ramp_next = since_ramp_inc;
                if (since_cmd_inc > dmrw_pkg::SINCE_CMD_W'(timeout_reg))
                begin
                    // watchdog expired
                    cur_left_next   = '0;
                    cur_right_next  = '0;
                    goal_left_next  = '0;
                    goal_right_next = '0;
                    since_cmd_next  = '0;
                    out_stop_next   = 1'b1;
                end
                else
                begin
                    since_cmd_next = since_cmd_inc;
                    if (since_ramp_inc > dmrw_pkg::SINCE_RAMP_W'(period_reg))
                    begin
                        since_ramp_next = '0;
                        cur_left_next   = left_lane.speed;
                        cur_right_next  = right_lane.speed;
                        out_lu_next     = left_lane.updated;
                        out_ru_next     = right_lane.updated;
                    end
                end
            end
            dmrw_pkg::CMD_SET:
            begin
                goal_left_next  = dmrw_pkg::clamp_speed(in_left_reg);
                goal_right_next = dmrw_pkg::clamp_speed(in_right_reg);
                since_cmd_next  = '0;
            end
            dmrw_pkg::CMD_STOP:
            begin
                cur_left_next   = '0;
                cur_right_next  = '0;
                goal_left_next  = '0;
                goal_right_next = '0;
                since_cmd_next  = '0;
                out_stop_next   = 1'b1;
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_left_reg   <= '0;
            cur_right_reg  <= '0;
            goal_left_reg  <= '0;
            goal_right_reg <= '0;
            since_cmd_reg  <= '0;
            since_ramp_reg <= '0;
        end
        else if (fire)
        begin
            cur_left_reg   <= cur_left_next;
            cur_right_reg  <= cur_right_next;
            goal_left_reg  <= goal_left_next;
            goal_right_reg <= goal_right_next;
            since_cmd_reg  <= since_cmd_next;
            since_ramp_reg <= since_ramp_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_left_reg  <= cur_left_next;
            out_right_reg <= cur_right_next;
            out_lu_reg    <= out_lu_next;
            out_ru_reg    <= out_ru_next;
            out_stop_reg  <= out_stop_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(dmrw_pkg::M_TDATA_W - 2 * SW)'(0), out_right_reg, out_left_reg};
    assign m_tuser  = {out_stop_reg, out_ru_reg, out_lu_reg};

    // Checks
    a_stop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata[2*SW-1:0] == '0))
        else $error("stop result with nonzero drive");

    a_stop_no_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[2] && (m_tuser[0] || m_tuser[1])))
        else $error("stop and ramp update in one result");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_left_reg >= dmrw_pkg::SPEED_MIN_DRV) && (cur_left_reg <= dmrw_pkg::SPEED_MAX_DRV)
        && (cur_right_reg >= dmrw_pkg::SPEED_MIN_DRV)
        && (cur_right_reg <= dmrw_pkg::SPEED_MAX_DRV))
        else $error("current speed out of range");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed request lost");

endmodule

`default_nettype wire

[rtl/dmrw_ramp_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmrw_ramp_lane (
    input  wire logic signed [dmrw_pkg::SPEED_W-1:0] cur,
    input  wire logic signed [dmrw_pkg::SPEED_W-1:0] goal,
    input  wire logic        [dmrw_pkg::STEP_W-1:0]  step,
    output dmrw_pkg::lane_result_t                   result
);

    // Two extra bits hold cur +/- step without overflow
    localparam int EXT_W = dmrw_pkg::SPEED_W + 2;

    logic signed [EXT_W-1:0] cur_ext;
    logic signed [EXT_W-1:0] goal_ext;
    logic signed [EXT_W-1:0] step_ext;
    logic signed [EXT_W-1:0] down;
    logic signed [EXT_W-1:0] up;

    assign cur_ext  = EXT_W'(cur);
    assign goal_ext = EXT_W'(goal);
    assign step_ext = $signed(EXT_W'(step));
    assign down     = cur_ext - step_ext;
    assign up       = cur_ext + step_ext;

    // Move toward goal by at most step, never past it
    always_comb
    begin
        result.speed   = cur;
        result.updated = 1'b0;
        if (goal_ext < cur_ext)
        begin
            result.updated = 1'b1;
            result.speed   = (down > goal_ext) ? down[dmrw_pkg::SPEED_W-1:0] : goal;
        end
        else if (goal_ext > cur_ext)
        begin
            result.updated = 1'b1;
            result.speed   = (up < goal_ext) ? up[dmrw_pkg::SPEED_W-1:0] : goal;
        end
    end

endmodule

`default_nettype wire
